// ===== hdl/p2v_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2v_pkg
// Shared constants and types of the phase to voltage solver.
// ----------------------------------------------------------------------------
package p2v_pkg;

    localparam int CHANNELS   = 4;
    localparam int NUM_REGS   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int REG_IDX_W  = 2;
    localparam int COEFF_W    = 64;
    localparam int PHASE_W    = 16;
    localparam int VOLT_W     = 16;

    localparam logic [16:0] WRAP_LIMIT = 17'd12800;
    localparam logic [16:0] WRAP_ADD   = 17'd46080;
    localparam logic [15:0] VMAX       = 16'd57344;
    localparam logic [15:0] VMID       = 16'd28672;

    localparam int SQ_STEPS   = 32;
    localparam int DIV_BITS   = 16;
    localparam int DIV_STAGES = DIV_BITS + 1;
    // front end, root, numerators, dividers, selection
    localparam int LANE_LAT   = 3 + SQ_STEPS + 2 + DIV_STAGES + 1;

    typedef logic [NUM_REGS-1:0][VOLT_W-1:0] t_volts;

    typedef struct packed {
        logic lin;
        logic bzero;
    } t_flags;

    typedef struct packed {
        logic signed [19:0] a;
        logic signed [21:0] b;
        logic signed [23:0] pc;
        t_flags             fl;
    } t_side;

endpackage

// ===== hdl/p2v_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2v_if
// Handshake channels of the phase to voltage solver.
// ----------------------------------------------------------------------------
interface p2v_in_if import p2v_pkg::*;;
    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] phase_0;
    logic [PHASE_W-1:0] phase_1;
    logic [PHASE_W-1:0] phase_2;
    logic [PHASE_W-1:0] phase_3;
    modport source (output valid, phase_0, phase_1, phase_2, phase_3, input ready);
    modport sink   (input valid, phase_0, phase_1, phase_2, phase_3, output ready);
endinterface

interface p2v_out_if import p2v_pkg::*;;
    logic              valid;
    logic              ready;
    logic [VOLT_W-1:0] volt_0;
    logic [VOLT_W-1:0] volt_1;
    logic [VOLT_W-1:0] volt_2;
    logic [VOLT_W-1:0] volt_3;
    modport source (output valid, volt_0, volt_1, volt_2, volt_3, input ready);
    modport sink   (input valid, volt_0, volt_1, volt_2, volt_3, output ready);
endinterface

interface p2v_cfg_if import p2v_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COEFF_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/p2v_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2v_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module p2v_sqrt import p2v_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    logic [34:0] r_rem  [SQ_STEPS];
    logic [31:0] r_root [SQ_STEPS];
    logic [63:0] r_rad  [SQ_STEPS-1];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        logic [34:0] w_rem_prev;
        logic [31:0] w_root_prev;
        logic [63:0] w_rad_prev;
        logic [34:0] w_cur;
        logic [34:0] w_trial;

        if (k == 0) begin : g_first
            assign w_rem_prev  = '0;
            assign w_root_prev = '0;
            assign w_rad_prev  = i_rad;
        end else begin : g_next
            assign w_rem_prev  = r_rem[k-1];
            assign w_root_prev = r_root[k-1];
            assign w_rad_prev  = r_rad[k-1];
        end

        assign w_cur   = {w_rem_prev[32:0], w_rad_prev[63:62]};
        assign w_trial = {1'b0, w_root_prev, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cur >= w_trial) begin
                    r_rem[k]  <= w_cur - w_trial;
                    r_root[k] <= {w_root_prev[30:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_cur;
                    r_root[k] <= {w_root_prev[30:0], 1'b0};
                end
            end
        end

        if (k < SQ_STEPS - 1) begin : g_rad
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k] <= {w_rad_prev[61:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[SQ_STEPS-1];

endmodule

// ===== hdl/p2v_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2v_div
// Pipelined restoring divider, floor quotient with sign and range flags.
// ----------------------------------------------------------------------------
module p2v_div import p2v_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [41:0]  i_num,
    input  logic [23:0]         i_den,
    output logic                o_neg,
    output logic                o_ovf,
    output logic [DIV_BITS-1:0] o_quo
);

    logic                r_neg [DIV_STAGES];
    logic                r_ovf [DIV_STAGES];
    logic [40:0]         r_rem [DIV_STAGES];
    logic [23:0]         r_den [DIV_STAGES];
    logic [DIV_BITS-1:0] r_quo [DIV_STAGES];

    // quotients of 2^16 and above are out of range anyway
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_num[41];
            r_ovf[0] <= !i_num[41] && (i_num[40:0] >= {1'b0, i_den, 16'b0});
            r_rem[0] <= i_num[40:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_bit
        logic [40:0] w_trial;
        assign w_trial = {17'b0, r_den[k-1]} << (DIV_BITS - k);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_den[k] <= r_den[k-1];
                if (r_rem[k-1] >= w_trial) begin
                    r_rem[k] <= r_rem[k-1] - w_trial;
                    r_quo[k] <= r_quo[k-1] | (DIV_BITS'(1) << (DIV_BITS - k));
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_quo[k] <= r_quo[k-1];
                end
            end
        end
    end

    assign o_neg = r_neg[DIV_STAGES-1];
    assign o_ovf = r_ovf[DIV_STAGES-1];
    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

// ===== hdl/p2v_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2v_lane
// One channel: discriminant, square root, three dividers and root selection.
// ----------------------------------------------------------------------------
module p2v_lane import p2v_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [PHASE_W-1:0] i_phase,
    input  logic [COEFF_W-1:0] i_coeff,
    output logic [VOLT_W-1:0]  o_volt
);

    // stage 0: phase wrap and p - c
    logic [16:0]        w_p;
    logic signed [23:0] w_pc;
    logic signed [19:0] r0_a;
    logic signed [21:0] r0_b;
    logic signed [23:0] r0_pc;

    assign w_p  = ({1'b0, i_phase} < WRAP_LIMIT) ? ({1'b0, i_phase} + WRAP_ADD)
                                                 : {1'b0, i_phase};
    assign w_pc = $signed({7'b0, w_p}) - $signed({{2{i_coeff[21]}}, i_coeff[21:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_a  <= i_coeff[63:44];
            r0_b  <= i_coeff[43:22];
            r0_pc <= w_pc;
        end
    end

    // stage 1: products
    logic signed [43:0] r1_bb;
    logic signed [43:0] r1_apc;
    logic signed [19:0] r1_a;
    logic signed [21:0] r1_b;
    logic signed [23:0] r1_pc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_bb  <= r0_b * r0_b;
            r1_apc <= r0_a * r0_pc;
            r1_a   <= r0_a;
            r1_b   <= r0_b;
            r1_pc  <= r0_pc;
        end
    end

    // stage 2: discriminant
    logic signed [47:0] w_dn;
    logic signed [47:0] r2_dn;
    t_side              r2_side;

    assign w_dn = $signed({{4{r1_bb[43]}}, r1_bb}) + $signed({r1_apc[42:0], 5'b0});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dn            <= w_dn;
            r2_side.a        <= r1_a;
            r2_side.b        <= r1_b;
            r2_side.pc       <= r1_pc;
            r2_side.fl.lin   <= w_dn[47] || (r1_a == '0);
            r2_side.fl.bzero <= (r1_b == '0);
        end
    end

    // square root of dn * 2^16 and side data alongside it
    logic [31:0] w_root;
    t_side       r_sd [SQ_STEPS];

    p2v_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rad  ({r2_dn, 16'b0}),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= r2_side;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // stage 3: -256b +/- s8
    t_side              w_sq;
    logic signed [33:0] w_b256;
    logic signed [33:0] r3_t1;
    logic signed [33:0] r3_t2;
    t_side              r3_side;

    assign w_sq   = r_sd[SQ_STEPS-1];
    assign w_b256 = $signed({{4{w_sq.b[21]}}, w_sq.b, 8'b0});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_t1   <= $signed({2'b0, w_root}) - w_b256;
            r3_t2   <= -w_b256 - $signed({2'b0, w_root});
            r3_side <= w_sq;
        end
    end

    // stage 4: sign normalise, numerators 2n + |d|, denominators 2|d|
    logic [19:0]        w_aabs;
    logic [21:0]        w_babs;
    logic signed [33:0] w_t1s;
    logic signed [33:0] w_t2s;
    logic signed [23:0] w_pcs;
    logic signed [41:0] r4_n1;
    logic signed [41:0] r4_n2;
    logic signed [41:0] r4_nl;
    logic [23:0]        r4_da;
    logic [23:0]        r4_db;
    t_flags             r4_fl;

    assign w_aabs = r3_side.a[19] ? 20'(-r3_side.a) : 20'(r3_side.a);
    assign w_babs = r3_side.b[21] ? 22'(-r3_side.b) : 22'(r3_side.b);
    assign w_t1s  = r3_side.a[19] ? -r3_t1 : r3_t1;
    assign w_t2s  = r3_side.a[19] ? -r3_t2 : r3_t2;
    assign w_pcs  = r3_side.b[21] ? -r3_side.pc : r3_side.pc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_n1 <= $signed({{4{w_t1s[33]}}, w_t1s, 4'b0}) + $signed({22'b0, w_aabs});
            r4_n2 <= $signed({{4{w_t2s[33]}}, w_t2s, 4'b0}) + $signed({22'b0, w_aabs});
            r4_nl <= $signed({{2{w_pcs[23]}}, w_pcs, 16'b0}) + $signed({20'b0, w_babs});
            r4_da <= {3'b0, w_aabs, 1'b0};
            r4_db <= {1'b0, w_babs, 1'b0};
            r4_fl <= r3_side.fl;
        end
    end

    // dividers
    logic                w_neg1, w_neg2, w_negl;
    logic                w_ovf1, w_ovf2, w_ovfl;
    logic [DIV_BITS-1:0] w_q1, w_q2, w_ql;
    t_flags              r_fd [DIV_STAGES];

    p2v_div u_div_plus (
        .i_clk (i_clk), .i_en (i_en), .i_num (r4_n1), .i_den (r4_da),
        .o_neg (w_neg1), .o_ovf (w_ovf1), .o_quo (w_q1)
    );

    p2v_div u_div_minus (
        .i_clk (i_clk), .i_en (i_en), .i_num (r4_n2), .i_den (r4_da),
        .o_neg (w_neg2), .o_ovf (w_ovf2), .o_quo (w_q2)
    );

    p2v_div u_div_lin (
        .i_clk (i_clk), .i_en (i_en), .i_num (r4_nl), .i_den (r4_db),
        .o_neg (w_negl), .o_ovf (w_ovfl), .o_quo (w_ql)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fd[0] <= r4_fl;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_fd[k] <= r_fd[k-1];
            end
        end
    end

    // stage 5: root choice, linear fallback and clamp
    t_flags            w_fl;
    logic              w_ok1, w_ok2;
    logic [VOLT_W-1:0] w_lin;
    logic [VOLT_W-1:0] w_d1, w_d2;
    logic [VOLT_W-1:0] n_volt;
    logic [VOLT_W-1:0] r_volt;

    assign w_fl  = r_fd[DIV_STAGES-1];
    assign w_ok1 = !w_neg1 && !w_ovf1 && (w_q1 <= VMAX);
    assign w_ok2 = !w_neg2 && !w_ovf2 && (w_q2 <= VMAX);
    assign w_d1  = (w_q1 >= VMID) ? (w_q1 - VMID) : (VMID - w_q1);
    assign w_d2  = (w_q2 >= VMID) ? (w_q2 - VMID) : (VMID - w_q2);

    always_comb begin
        if (w_fl.bzero || w_negl) begin
            w_lin = '0;
        end else if (w_ovfl || (w_ql > VMAX)) begin
            w_lin = VMAX;
        end else begin
            w_lin = w_ql;
        end

        if (w_fl.lin) begin
            n_volt = w_lin;
        end else if (w_ok1 && w_ok2) begin
            n_volt = (w_d1 <= w_d2) ? w_q1 : w_q2;
        end else if (w_ok1) begin
            n_volt = w_q1;
        end else if (w_ok2) begin
            n_volt = w_q2;
        end else begin
            n_volt = w_lin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_volt <= n_volt;
        end
    end

    assign o_volt = r_volt;

endmodule

// ===== hdl/phase_to_voltage_quadratic_solver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_to_voltage_quadratic_solver_top
// Four-channel phase to bias voltage solver, calibration curve inversion.
// ----------------------------------------------------------------------------
// usage
// i_in carries four phases per transaction; o_out returns four voltages in
// 1/4096 V, one result transaction for each input transaction, in order.
// i_cfg writes the packed a/b/c coefficients of channel i at index i; indexes
// above 3 are dropped. write only while the block is empty.
// each channel has its own lane: wrap, discriminant, a 32-stage square root
// and three 17-stage dividers, all fully pipelined.
// throughput: one transaction per cycle while o_out is not stalled.
// a two-entry output queue holds results when the receiver stalls; input is
// still taken until that queue is full and a result waits at the lane end,
// then the whole pipeline freezes and nothing is lost or repeated.
// reset clears the coefficients to zero and empties the pipeline and queue;
// no clearing pass follows, the block is ready in the first cycle after.
// ----------------------------------------------------------------------------
module phase_to_voltage_quadratic_solver_top import p2v_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    p2v_cfg_if.sink   i_cfg,
    p2v_in_if.sink    i_in,
    p2v_out_if.source o_out
);

    logic [COEFF_W-1:0] r_coeff [NUM_REGS];
    logic [PHASE_W-1:0] w_phase [NUM_REGS];
    t_volts             w_volts;
    logic               r_vld [LANE_LAT];
    t_volts             r_slot [2];
    logic [1:0]         r_cnt;
    logic               w_en;
    logic               w_push;
    logic               w_pop;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_coeff[k] <= '0;
            end
        end else if (i_cfg.valid && (i_cfg.index < CFG_IDX_W'(NUM_REGS))) begin
            r_coeff[i_cfg.index[REG_IDX_W-1:0]] <= i_cfg.data;
        end
    end

    assign w_phase[0] = i_in.phase_0;
    assign w_phase[1] = i_in.phase_1;
    assign w_phase[2] = i_in.phase_2;
    assign w_phase[3] = i_in.phase_3;

    // pipeline advances unless the queue is full and a result waits at the end
    assign w_en       = (r_cnt != 2'd2) || !r_vld[LANE_LAT-1];
    assign i_in.ready = w_en;

    for (genvar i = 0; i < NUM_REGS; i++) begin : g_lane
        if (i < CHANNELS) begin : g_on
            p2v_lane u_lane (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_phase (w_phase[i]),
                .i_coeff (r_coeff[i]),
                .o_volt  (w_volts[i])
            );
        end else begin : g_off
            assign w_volts[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // output queue
    assign w_push = w_en && r_vld[LANE_LAT-1];
    assign w_pop  = (r_cnt != 2'd0) && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_slot[0] <= (w_push && (r_cnt == 2'd1)) ? w_volts : r_slot[1];
            if (w_push) begin
                r_slot[1] <= w_volts;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_slot[0] <= w_volts;
            end else begin
                r_slot[1] <= w_volts;
            end
        end
    end

    assign o_out.valid  = (r_cnt != 2'd0);
    assign o_out.volt_0 = r_slot[0][0];
    assign o_out.volt_1 = r_slot[0][1];
    assign o_out.volt_2 = r_slot[0][2];
    assign o_out.volt_3 = r_slot[0][3];

endmodule

// ===== hdl/p2v_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2v_checker
// Port-level checks of the phase to voltage solver, bound to the top level.
// ----------------------------------------------------------------------------
module p2v_checker import p2v_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [VOLT_W-1:0] i_volt_0,
    input logic [VOLT_W-1:0] i_volt_1,
    input logic [VOLT_W-1:0] i_volt_2,
    input logic [VOLT_W-1:0] i_volt_3
);

    // clamp must hold on every delivered voltage
    a_volt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_volt_0 <= VMAX) && (i_volt_1 <= VMAX) &&
                        (i_volt_2 <= VMAX) && (i_volt_3 <= VMAX))
        else $error("voltage above clamp");

    // reset empties the output queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind phase_to_voltage_quadratic_solver_top p2v_checker u_p2v_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_ready (i_cfg.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_volt_0    (o_out.volt_0),
    .i_volt_1    (o_out.volt_1),
    .i_volt_2    (o_out.volt_2),
    .i_volt_3    (o_out.volt_3)
);
